// ===== hdl/i2cm_pkg.sv =====
package i2cm_pkg;

   // command codes as they arrive on the request channel
   typedef enum logic [2:0] {
      CMD_IDLE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_RESTART   = 3'd2,
      CMD_STOP      = 3'd3,
      CMD_WRITE     = 3'd4,
      CMD_READ_ACK  = 3'd5,
      CMD_READ_NACK = 3'd6
   } cmd_type;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 16;

   localparam logic [5:0] BYTE_PHASES = 6'd32;
   localparam logic [5:0] LONG_LAST   = 6'd35;
   localparam logic [5:0] SHORT_LAST  = 6'd3;
   localparam logic [5:0] STOP_LAST   = 6'd2;
   localparam logic [2:0] BIT_TOP     = 3'd7;

   // quarter positions inside one bit time
   localparam logic [1:0] Q_DRIVE  = 2'd0;
   localparam logic [1:0] Q_RISE   = 2'd1;
   localparam logic [1:0] Q_SAMPLE = 2'd2;

   // one classified tick waiting for the engine
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       sda_in;
   } tick_type;

   // handshake between front and back
   typedef struct packed {
      logic     valid;
      tick_type item;
   } head_type;

endpackage

// ===== hdl/i2cm_front.sv =====
module i2cm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [i2cm_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output i2cm_pkg::head_type                  head,
   input  logic                                pop
);
   import i2cm_pkg::*;

   tick_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   tick_type   tick;
   logic       push;
   logic       do_pop;

   // code 7 behaves as a plain tick
   always_comb begin
      tick.tx_byte = req_tdata[7:0];
      tick.sda_in  = req_tdata[8];
      unique case (req_tuser)
         3'd1:    tick.cmd = CMD_START;
         3'd2:    tick.cmd = CMD_RESTART;
         3'd3:    tick.cmd = CMD_STOP;
         3'd4:    tick.cmd = CMD_WRITE;
         3'd5:    tick.cmd = CMD_READ_ACK;
         3'd6:    tick.cmd = CMD_READ_NACK;
         default: tick.cmd = CMD_IDLE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= tick;
      end
   end

endmodule

// ===== hdl/i2cm_back.sv =====
module i2cm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              auto_stop,
   input  i2cm_pkg::head_type                head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import i2cm_pkg::*;

   cmd_type    state_ff, state_in;
   logic [5:0] phase_ff, phase_in;
   logic [7:0] shift_ff, shift_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;
   logic [7:0] rx_ff, rx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   cmd_type    cmd;
   logic [5:0] ph;
   logic [1:0] q;
   logic       rej;
   logic       done;
   logic       last;
   tick_type   t;

   assign t   = head.item;
   assign pop = head.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      cmd      = state_ff;
      ph       = phase_ff;
      rej      = 1'b0;
      done     = 1'b0;
      last     = 1'b0;

      // a command is taken only when idle, else flagged
      if (state_ff == CMD_IDLE) begin
         if (t.cmd != CMD_IDLE) begin
            cmd = t.cmd;
            ph  = 6'd0;
            if (t.cmd == CMD_WRITE) begin
               shift_in = t.tx_byte;
            end else if (t.cmd == CMD_READ_ACK || t.cmd == CMD_READ_NACK) begin
               shift_in = 8'd0;
            end
         end
      end else if (t.cmd != CMD_IDLE) begin
         rej = 1'b1;
      end

      q = ph[1:0];
      unique case (cmd)
         CMD_IDLE: begin
         end
         CMD_START: begin
            last = (ph == SHORT_LAST);
            if (ph == 6'd0) scl_in = 1'b1;
            else if (ph == 6'd1) sda_in = 1'b1;
            else if (ph == 6'd2) sda_in = 1'b0;
            else scl_in = 1'b0;
         end
         CMD_RESTART: begin
            last = (ph == SHORT_LAST);
            if (ph == 6'd0) sda_in = 1'b1;
            else if (ph == 6'd1) scl_in = 1'b1;
            else if (ph == 6'd2) sda_in = 1'b0;
            else scl_in = 1'b0;
         end
         CMD_STOP: begin
            last = (ph == STOP_LAST);
            if (ph == 6'd0) begin
               scl_in = 1'b0;
               sda_in = 1'b0;
            end else if (ph == 6'd1) scl_in = 1'b1;
            else sda_in = 1'b1;
         end
         CMD_WRITE: begin
            last = (ph == LONG_LAST);
            if (ph < BYTE_PHASES) begin
               // msb first: bit index counts down with the bit slot
               if (q == Q_DRIVE) sda_in = shift_in[BIT_TOP - ph[4:2]];
               else if (q == Q_RISE) scl_in = 1'b1;
               else if (q != Q_SAMPLE) scl_in = 1'b0;
            end else begin
               if (q == Q_DRIVE) sda_in = 1'b1;
               else if (q == Q_RISE) scl_in = 1'b1;
               else if (q == Q_SAMPLE) ack_in = ~t.sda_in;
               else scl_in = 1'b0;
            end
         end
         CMD_READ_ACK, CMD_READ_NACK: begin
            last = (ph == LONG_LAST);
            if (ph < BYTE_PHASES) begin
               if (q == Q_DRIVE) sda_in = 1'b1;
               else if (q == Q_RISE) scl_in = 1'b1;
               else if (q == Q_SAMPLE) shift_in = {shift_in[6:0], t.sda_in};
               else scl_in = 1'b0;
            end else begin
               if (q == Q_DRIVE) sda_in = (cmd == CMD_READ_NACK);
               else if (q == Q_RISE) scl_in = 1'b1;
               else if (q != Q_SAMPLE) scl_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (cmd != CMD_IDLE) begin
         if (last) begin
            phase_in = 6'd0;
            if (cmd == CMD_WRITE && !ack_in && auto_stop) begin
               // nack: append a stop before reporting completion
               state_in = CMD_STOP;
            end else begin
               if (cmd == CMD_READ_ACK || cmd == CMD_READ_NACK) rx_in = shift_in;
               state_in = CMD_IDLE;
               done     = 1'b1;
            end
         end else begin
            state_in = cmd;
            phase_in = ph + 6'd1;
         end
      end

      rsp_data_in = {2'b00, rej, rx_in, ack_in, done, (state_in != CMD_IDLE), sda_in, scl_in};
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CMD_IDLE;
         phase_ff     <= 6'd0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         rx_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            state_ff <= state_in;
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            rx_ff    <= rx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/i2c_master_bit_engine_core.sv =====
// channel   | direction | payload, lowest bit first
// req_      | in        | tuser: req_type[2:0]; tdata: tx_byte[7:0], sda_in[8]
// rsp_      | out       | tdata: scl_level, sda_level, busy_res, done_res, ack_ok,
//           |           |        rx_byte[12:5], rejected[13]
// csr_      | in        | data: auto_stop_on_nack
//
// one request tick per clock, one response per request; the engine steps once per
// accepted tick, so the rate is set by the response handshake alone
// a request passes through the queue entry and the response register before its response can transfer
// a two-entry queue between decode and engine absorbs response stalls;
// req_tready drops only when that queue is full
// synchronous reset releases both pins and clears the queue and the output valid
module i2c_master_bit_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]    req_tdata,   // tx_byte, sda_in
   input  logic [i2cm_pkg::REQ_TUSER_W-1:0]    req_tuser,   // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // scl, sda, busy, done, ack, rx, rej
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data
);
   import i2cm_pkg::*;

   head_type head;
   logic     pop;
   logic     auto_stop_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_stop_ff <= 1'b1;
      end else if (csr_valid) begin
         auto_stop_ff <= csr_data;
      end
   end

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   i2cm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .auto_stop  (auto_stop_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/i2cm_checker.sv =====
module i2cm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [i2cm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a finished sequence is never still busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[2]))
      else $error("done and busy together");

   // a rejection only happens while a sequence runs or ends on that tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[2] || rsp_tdata[3])
      else $error("rejection while idle");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
